// ===== src/utrb_pkg.sv =====
// Shared types and constants for the UART byte ring block.
// No dependencies; imported by the top level.
package utrb_pkg;

	localparam int unsigned TX_DEPTH_DEF = 64;
	localparam int unsigned RX_DEPTH_DEF = 64;

	localparam int unsigned MODE_W   = 3;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 6;
	localparam int unsigned FILL_W   = 6;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned CNT_W    = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_RX_BYTE   = 3'd0,
		MODE_TX_ENQ    = 3'd1,
		MODE_TX_SLOT   = 3'd2,
		MODE_RX_READ   = 3'd3,
		MODE_READLINE  = 3'd4,
		MODE_CLR_STATS = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK       = 3'd0,
		STS_RX_DROP  = 3'd1,
		STS_TX_FULL  = 3'd2,
		STS_EMPTY    = 3'd3,
		STS_NO_LINE  = 3'd4,
		STS_TOO_LONG = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TX_RD,
		S_RX_RD,
		S_SCAN,
		S_EMIT_RD,
		S_EMIT_OUT,
		S_PUT
	} state_t;

endpackage

// ===== src/utrb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module utrb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/uart_tx_rx_ring_buffers.sv =====
// UART rx and tx byte rings between a serial line and a host. Uses utrb_pkg and utrb_ram.
// Rx byte, tx enqueue and clear stats go from idle straight to the result state; tx slot and rx
// read pass a RAM read state first when there is a byte. Readline scans the bytes up to the delimiter
// (or the whole fill), then reads and puts out each line byte in turn, or loads one result when no byte goes out.
// One transaction at a time: the next input is taken once the result is loaded.
// Reset (arst_n, async) clears pointers, counters, FSM, out valid; RAMs not cleared.
module uart_tx_rx_ring_buffers import utrb_pkg::*; #(
	parameter int unsigned TX_DEPTH = TX_DEPTH_DEF,
	parameter int unsigned RX_DEPTH = RX_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// input transaction
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [MODE_W-1:0]   mode,
	input  logic [BYTE_W-1:0]   data,
	input  logic                line_ready,
	input  logic [BYTE_W-1:0]   delimiter,
	input  logic [LEN_W-1:0]    max_len,
	// result transaction
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [BYTE_W-1:0]   out_byte,
	output logic                byte_valid,
	output logic                last,
	output logic [LEN_W-1:0]    line_length,
	output logic [FILL_W-1:0]   rx_fill,
	output logic [FILL_W-1:0]   tx_fill,
	output logic [CNT_W-1:0]    rx_received_total,
	output logic [CNT_W-1:0]    rx_overflow_total,
	output logic [CNT_W-1:0]    tx_enqueued_total,
	output logic [CNT_W-1:0]    tx_overflow_total,
	output logic [CNT_W-1:0]    tx_sent_total
);

	localparam int unsigned TX_AW = $clog2(TX_DEPTH);
	localparam int unsigned RX_AW = $clog2(RX_DEPTH);
	// width for comparing a scanned line length against max_len
	localparam int unsigned CMP_W = (RX_AW > LEN_W) ? RX_AW : LEN_W;

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	state_t              state_q, state_nxt;
	logic [TX_AW-1:0]    tx_head_q, tx_tail_q;
	logic [RX_AW-1:0]    rx_head_q, rx_tail_q;
	logic [CNT_W-1:0]    cnt_rx_rcv_q, cnt_rx_ovf_q, cnt_tx_enq_q, cnt_tx_ovf_q, cnt_tx_sent_q;

	// per-transaction working registers
	logic [BYTE_W-1:0]   delim_q;
	logic [LEN_W-1:0]    maxl_q;
	logic [RX_AW-1:0]    scan_q;      // index of the byte now on the RAM read port
	logic [RX_AW-1:0]    base_q;      // start of the line being emitted
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    em_q;        // index of the line byte being emitted
	status_t             res_status_q;
	logic [BYTE_W-1:0]   res_byte_q;
	logic                res_bvalid_q;

	// result register
	logic                out_valid_q;
	status_t             out_status_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                out_bvalid_q;
	logic                out_last_q;
	logic [LEN_W-1:0]    out_len_q;
	logic [FILL_W-1:0]   out_rx_fill_q, out_tx_fill_q;
	logic [CNT_W-1:0]    out_rx_rcv_q, out_rx_ovf_q, out_tx_enq_q, out_tx_ovf_q, out_tx_sent_q;

	// ---------------------------------------------------------------
	// Ring status
	// ---------------------------------------------------------------
	mode_t               mode_in;
	logic                accept;
	logic                out_free;
	logic [TX_AW-1:0]    tx_fill_w, tx_nxt;
	logic [RX_AW-1:0]    rx_fill_w, rx_nxt;
	logic                tx_full, tx_empty, rx_full, rx_empty;

	assign mode_in   = mode_t'(mode);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// power-of-two depths: pointer arithmetic wraps naturally
	assign tx_fill_w = tx_tail_q - tx_head_q;
	assign rx_fill_w = rx_tail_q - rx_head_q;
	assign tx_nxt    = tx_tail_q + TX_AW'(1);
	assign rx_nxt    = rx_tail_q + RX_AW'(1);
	assign tx_full   = (tx_nxt == tx_head_q);
	assign rx_full   = (rx_nxt == rx_head_q);
	assign tx_empty  = (tx_head_q == tx_tail_q);
	assign rx_empty  = (rx_head_q == rx_tail_q);

	// ---------------------------------------------------------------
	// Ring memories
	// ---------------------------------------------------------------
	logic                tx_we, rx_we;
	logic [TX_AW-1:0]    tx_raddr;
	logic [RX_AW-1:0]    rx_raddr;
	logic [BYTE_W-1:0]   tx_rdata, rx_rdata;

	utrb_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk     (clk),
		.wr_en   (tx_we),
		.wr_addr (tx_tail_q),
		.wr_data (data),
		.rd_addr (tx_raddr),
		.rd_data (tx_rdata)
	);

	utrb_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk     (clk),
		.wr_en   (rx_we),
		.wr_addr (rx_tail_q),
		.wr_data (data),
		.rd_addr (rx_raddr),
		.rd_data (rx_rdata)
	);

	// ---------------------------------------------------------------
	// Readline scan and emit terms
	// ---------------------------------------------------------------
	logic                hit, too_long, scan_end, emit_last;

	assign hit       = (rx_rdata == delim_q);
	assign too_long  = (CMP_W'(scan_q) > CMP_W'(maxl_q));
	assign scan_end  = ((scan_q + RX_AW'(1)) == rx_fill_w);
	assign emit_last = ((em_q + LEN_W'(1)) == len_q);

	// ---------------------------------------------------------------
	// Next state
	// ---------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		unique case (state_q) inside
			S_IDLE: begin
				if (in_valid) begin
					unique case (mode_in)
						MODE_TX_SLOT:  state_nxt = (tx_empty || !line_ready) ? S_PUT : S_TX_RD;
						MODE_RX_READ:  state_nxt = rx_empty ? S_PUT : S_RX_RD;
						MODE_READLINE: state_nxt = rx_empty ? S_PUT : S_SCAN;
						default:       state_nxt = S_PUT;
					endcase
				end
			end
			S_TX_RD, S_RX_RD: state_nxt = S_PUT;
			S_SCAN: begin
				if (hit) begin
					state_nxt = (too_long || (scan_q == '0)) ? S_PUT : S_EMIT_RD;
				end else if (scan_end) begin
					state_nxt = S_PUT;
				end
			end
			S_EMIT_RD: state_nxt = S_EMIT_OUT;
			S_EMIT_OUT: begin
				if (out_free) begin
					state_nxt = emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			S_PUT: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// Memory and result control
	// ---------------------------------------------------------------
	logic                put_load, emit_load;

	always_comb begin
		rx_we     = accept && (mode_in == MODE_RX_BYTE);
		tx_we     = accept && (mode_in == MODE_TX_ENQ) && !tx_full;
		tx_raddr  = tx_head_q;
		put_load  = (state_q == S_PUT) && out_free;
		emit_load = (state_q == S_EMIT_OUT) && out_free;
		unique case (state_q) inside
			// fetch one ahead of the byte under compare
			S_SCAN:                rx_raddr = rx_head_q + scan_q + RX_AW'(1);
			S_EMIT_RD, S_EMIT_OUT: rx_raddr = base_q + RX_AW'(em_q);
			default:               rx_raddr = rx_head_q;
		endcase
	end

	// ---------------------------------------------------------------
	// Pointers, counters, state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			tx_head_q     <= '0;
			tx_tail_q     <= '0;
			rx_head_q     <= '0;
			rx_tail_q     <= '0;
			cnt_rx_rcv_q  <= '0;
			cnt_rx_ovf_q  <= '0;
			cnt_tx_enq_q  <= '0;
			cnt_tx_ovf_q  <= '0;
			cnt_tx_sent_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (mode_in)
							MODE_RX_BYTE: begin
								rx_tail_q <= rx_nxt;
								if (rx_full) begin
									// overwrite: drop oldest, keep new byte
									rx_head_q    <= rx_head_q + RX_AW'(1);
									cnt_rx_ovf_q <= cnt_rx_ovf_q + CNT_W'(1);
								end else begin
									cnt_rx_rcv_q <= cnt_rx_rcv_q + CNT_W'(1);
								end
							end
							MODE_TX_ENQ: begin
								if (tx_full) begin
									cnt_tx_ovf_q <= cnt_tx_ovf_q + CNT_W'(1);
								end else begin
									tx_tail_q    <= tx_nxt;
									cnt_tx_enq_q <= cnt_tx_enq_q + CNT_W'(1);
								end
							end
							MODE_CLR_STATS: begin
								cnt_rx_rcv_q  <= '0;
								cnt_rx_ovf_q  <= '0;
								cnt_tx_enq_q  <= '0;
								cnt_tx_ovf_q  <= '0;
								cnt_tx_sent_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_TX_RD: begin
					tx_head_q     <= tx_head_q + TX_AW'(1);
					cnt_tx_sent_q <= cnt_tx_sent_q + CNT_W'(1);
				end
				S_RX_RD: rx_head_q <= rx_head_q + RX_AW'(1);
				S_SCAN: begin
					// consume line and delimiter up front so fills read post-op
					if (hit && !too_long) begin
						rx_head_q <= rx_head_q + scan_q + RX_AW'(1);
					end
				end
				default: ;
			endcase

			if (put_load || emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Working and result payload
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			delim_q      <= delimiter;
			maxl_q       <= max_len;
			scan_q       <= '0;
			res_byte_q   <= '0;
			res_bvalid_q <= 1'b0;
			case (mode_in)
				MODE_RX_BYTE:  res_status_q <= rx_full ? STS_RX_DROP : STS_OK;
				MODE_TX_ENQ:   res_status_q <= tx_full ? STS_TX_FULL : STS_OK;
				MODE_TX_SLOT:  res_status_q <= STS_EMPTY;
				MODE_RX_READ:  res_status_q <= STS_EMPTY;
				MODE_READLINE: res_status_q <= STS_NO_LINE;
				default:       res_status_q <= STS_OK;
			endcase
		end

		case (state_q)
			S_TX_RD: begin
				res_byte_q   <= tx_rdata;
				res_bvalid_q <= 1'b1;
				res_status_q <= STS_OK;
			end
			S_RX_RD: begin
				res_byte_q   <= rx_rdata;
				res_bvalid_q <= 1'b1;
				res_status_q <= STS_OK;
			end
			S_SCAN: begin
				scan_q <= scan_q + RX_AW'(1);
				if (hit) begin
					res_status_q <= too_long ? STS_TOO_LONG : STS_OK;
					base_q       <= rx_head_q;
					len_q        <= LEN_W'(scan_q);
					em_q         <= '0;
				end
			end
			S_EMIT_OUT: begin
				if (out_free) begin
					em_q <= em_q + LEN_W'(1);
				end
			end
			default: ;
		endcase

		if (put_load || emit_load) begin
			out_rx_fill_q <= FILL_W'(rx_fill_w);
			out_tx_fill_q <= FILL_W'(tx_fill_w);
			out_rx_rcv_q  <= cnt_rx_rcv_q;
			out_rx_ovf_q  <= cnt_rx_ovf_q;
			out_tx_enq_q  <= cnt_tx_enq_q;
			out_tx_ovf_q  <= cnt_tx_ovf_q;
			out_tx_sent_q <= cnt_tx_sent_q;
		end
		if (put_load) begin
			out_status_q <= res_status_q;
			out_byte_q   <= res_byte_q;
			out_bvalid_q <= res_bvalid_q;
			out_last_q   <= 1'b1;
			out_len_q    <= '0;
		end else if (emit_load) begin
			out_status_q <= STS_OK;
			out_byte_q   <= rx_rdata;
			out_bvalid_q <= 1'b1;
			out_last_q   <= emit_last;
			out_len_q    <= len_q;
		end
	end

	// ---------------------------------------------------------------
	// Outputs
	// ---------------------------------------------------------------
	assign out_valid         = out_valid_q;
	assign status            = out_status_q;
	assign out_byte          = out_byte_q;
	assign byte_valid        = out_bvalid_q;
	assign last              = out_last_q;
	assign line_length       = out_len_q;
	assign rx_fill           = out_rx_fill_q;
	assign tx_fill           = out_tx_fill_q;
	assign rx_received_total = out_rx_rcv_q;
	assign rx_overflow_total = out_rx_ovf_q;
	assign tx_enqueued_total = out_tx_enq_q;
	assign tx_overflow_total = out_tx_ovf_q;
	assign tx_sent_total     = out_tx_sent_q;

endmodule

// ===== bench/ring_check_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the UART byte rings: a behavioural copy of both rings and the
// five traffic counters, plus the queue of results the block still owes.
// Depends on utrb_pkg.
package ring_check_pkg;
	import utrb_pkg::*;

	// Mode codes the block does not define; they must leave the state alone.
	localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   out_byte;
		logic                byte_valid;
		logic                last;
		logic [LEN_W-1:0]    line_length;
		logic [FILL_W-1:0]   rx_fill;
		logic [FILL_W-1:0]   tx_fill;
		logic [CNT_W-1:0]    rx_received_total;
		logic [CNT_W-1:0]    rx_overflow_total;
		logic [CNT_W-1:0]    tx_enqueued_total;
		logic [CNT_W-1:0]    tx_overflow_total;
		logic [CNT_W-1:0]    tx_sent_total;
	} ring_result_t;

	class ring_scoreboard;
		logic [BYTE_W-1:0] rx_mem [RX_DEPTH_DEF];
		logic [BYTE_W-1:0] tx_mem [TX_DEPTH_DEF];
		logic [FILL_W-1:0] rx_rd, rx_wr, tx_rd, tx_wr;
		logic [CNT_W-1:0]  n_rx_ok, n_rx_drop, n_tx_ok, n_tx_drop, n_tx_sent;
		ring_result_t      owed_q [$];
		int                n_errors, n_checked, n_lines, n_drops, n_rejects;

		function new();
			rx_rd = '0; rx_wr = '0; tx_rd = '0; tx_wr = '0;
			n_rx_ok = '0; n_rx_drop = '0; n_tx_ok = '0; n_tx_drop = '0; n_tx_sent = '0;
			n_errors = 0; n_checked = 0;
			n_lines = 0; n_drops = 0; n_rejects = 0;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// Queue one result; fills and counters are taken from the state as it now stands.
		function void owe(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] b, logic bv,
				logic lst, logic [LEN_W-1:0] len);
			ring_result_t r;
			r.status            = st;
			r.out_byte          = b;
			r.byte_valid        = bv;
			r.last              = lst;
			r.line_length       = len;
			r.rx_fill           = rx_wr - rx_rd;
			r.tx_fill           = tx_wr - tx_rd;
			r.rx_received_total = n_rx_ok;
			r.rx_overflow_total = n_rx_drop;
			r.tx_enqueued_total = n_tx_ok;
			r.tx_overflow_total = n_tx_drop;
			r.tx_sent_total     = n_tx_sent;
			owed_q.push_back(r);
		endfunction

		function void note_input(logic [MODE_W-1:0] m, logic [BYTE_W-1:0] d, logic rdy,
				logic [BYTE_W-1:0] delim, logic [LEN_W-1:0] maxl);
			logic [FILL_W-1:0] nxt, fill, idx, base;
			int len, i;
			bit found;
			case (m)
			MODE_RX_BYTE: begin
				nxt = rx_wr + 1'b1;
				rx_mem[rx_wr] = d;
				if (nxt == rx_rd) begin
					// full: oldest byte goes, new one is kept
					rx_rd = rx_rd + 1'b1;
					rx_wr = nxt;
					n_rx_drop++;
					n_drops++;
					owe(STS_RX_DROP, '0, 1'b0, 1'b1, '0);
				end else begin
					rx_wr = nxt;
					n_rx_ok++;
					owe(STS_OK, '0, 1'b0, 1'b1, '0);
				end
			end
			MODE_TX_ENQ: begin
				nxt = tx_wr + 1'b1;
				if (nxt == tx_rd) begin
					n_tx_drop++;
					n_rejects++;
					owe(STS_TX_FULL, '0, 1'b0, 1'b1, '0);
				end else begin
					tx_mem[tx_wr] = d;
					tx_wr = nxt;
					n_tx_ok++;
					owe(STS_OK, '0, 1'b0, 1'b1, '0);
				end
			end
			MODE_TX_SLOT: begin
				if (tx_rd == tx_wr || !rdy) begin
					owe(STS_EMPTY, '0, 1'b0, 1'b1, '0);
				end else begin
					idx = tx_rd;
					tx_rd = tx_rd + 1'b1;
					n_tx_sent++;
					owe(STS_OK, tx_mem[idx], 1'b1, 1'b1, '0);
				end
			end
			MODE_RX_READ: begin
				if (rx_rd == rx_wr) begin
					owe(STS_EMPTY, '0, 1'b0, 1'b1, '0);
				end else begin
					idx = rx_rd;
					rx_rd = rx_rd + 1'b1;
					owe(STS_OK, rx_mem[idx], 1'b1, 1'b1, '0);
				end
			end
			MODE_READLINE: begin
				fill = rx_wr - rx_rd;
				found = 1'b0;
				len = 0;
				while (!found && len < fill) begin
					idx = FILL_W'(rx_rd + len);
					if (rx_mem[idx] == delim)
						found = 1'b1;
					else
						len++;
				end
				if (!found) begin
					owe(STS_NO_LINE, '0, 1'b0, 1'b1, '0);
				end else if (len > maxl) begin
					owe(STS_TOO_LONG, '0, 1'b0, 1'b1, '0);
				end else begin
					base = rx_rd;
					rx_rd = FILL_W'(rx_rd + len + 1);
					n_lines++;
					if (len == 0) begin
						owe(STS_OK, '0, 1'b0, 1'b1, '0);
					end else begin
						for (i = 0; i < len; i++) begin
							idx = FILL_W'(base + i);
							owe(STS_OK, rx_mem[idx], 1'b1, i == len - 1, LEN_W'(len));
						end
					end
				end
			end
			MODE_CLR_STATS: begin
				n_rx_ok = '0; n_rx_drop = '0; n_tx_ok = '0; n_tx_drop = '0; n_tx_sent = '0;
				owe(STS_OK, '0, 1'b0, 1'b1, '0);
			end
			default: owe(STS_OK, '0, 1'b0, 1'b1, '0);
			endcase
		endfunction

		function void cmp(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
			if (got !== want) begin
				n_errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, name, want, got);
			end
		endfunction

		function void check_result(ring_result_t got);
			ring_result_t want;
			n_checked++;
			if (owed_q.size() == 0) begin
				n_errors++;
				$display("%0t: result with none expected, expected nothing, actual %h",
					$time, got);
				return;
			end
			want = owed_q.pop_front();
			cmp("status", CNT_W'(want.status), CNT_W'(got.status));
			cmp("out_byte", CNT_W'(want.out_byte), CNT_W'(got.out_byte));
			cmp("byte_valid", CNT_W'(want.byte_valid), CNT_W'(got.byte_valid));
			cmp("last", CNT_W'(want.last), CNT_W'(got.last));
			cmp("line_length", CNT_W'(want.line_length), CNT_W'(got.line_length));
			cmp("rx_fill", CNT_W'(want.rx_fill), CNT_W'(got.rx_fill));
			cmp("tx_fill", CNT_W'(want.tx_fill), CNT_W'(got.tx_fill));
			cmp("rx_received_total", want.rx_received_total, got.rx_received_total);
			cmp("rx_overflow_total", want.rx_overflow_total, got.rx_overflow_total);
			cmp("tx_enqueued_total", want.tx_enqueued_total, got.tx_enqueued_total);
			cmp("tx_overflow_total", want.tx_overflow_total, got.tx_overflow_total);
			cmp("tx_sent_total", want.tx_sent_total, got.tx_sent_total);
		endfunction
	endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Top-level bench for uart_tx_rx_ring_buffers: directed and random byte traffic,
// readline and statistics operations, checked against ring_scoreboard.
// Depends on utrb_pkg, ring_check_pkg and the block's RTL.
module tb_top;
	import utrb_pkg::*;
	import ring_check_pkg::*;

	localparam int TARGET_ITEMS = 430;
	// long enough for the worst readline (full scan plus 62 bytes out) to drain
	localparam int TAIL_CYCLES  = 300;
	// generous ceiling: 430 transactions, each at worst a 62-byte line under stalls
	localparam int RUN_LIMIT_NS = 5_000_000;
	localparam int IDLE_PCT     = 17;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [MODE_W-1:0]   mode;
	logic [BYTE_W-1:0]   data;
	logic                line_ready;
	logic [BYTE_W-1:0]   delimiter;
	logic [LEN_W-1:0]    max_len;
	logic                out_valid;
	logic                out_stall;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   out_byte;
	logic                byte_valid;
	logic                last;
	logic [LEN_W-1:0]    line_length;
	logic [FILL_W-1:0]   rx_fill;
	logic [FILL_W-1:0]   tx_fill;
	logic [CNT_W-1:0]    rx_received_total;
	logic [CNT_W-1:0]    rx_overflow_total;
	logic [CNT_W-1:0]    tx_enqueued_total;
	logic [CNT_W-1:0]    tx_overflow_total;
	logic [CNT_W-1:0]    tx_sent_total;

	ring_scoreboard sb;
	ring_result_t   seen;
	int             n_sent;
	// set during a stretch of the random part: no input gaps, no output stalls
	bit             calm;

	uart_tx_rx_ring_buffers dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Output back-pressure: changes on the falling edge only.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Monitor. Sampled right at the rising edge, before the block's own updates land,
	// so both handshakes are seen with the values that the flops see.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(mode, data, line_ready, delimiter, max_len);
			if (out_valid && !out_stall) begin
				seen.status            = status;
				seen.out_byte          = out_byte;
				seen.byte_valid        = byte_valid;
				seen.last              = last;
				seen.line_length       = line_length;
				seen.rx_fill           = rx_fill;
				seen.tx_fill           = tx_fill;
				seen.rx_received_total = rx_received_total;
				seen.rx_overflow_total = rx_overflow_total;
				seen.tx_enqueued_total = tx_enqueued_total;
				seen.tx_overflow_total = tx_overflow_total;
				seen.tx_sent_total     = tx_sent_total;
				sb.check_result(seen);
			end
		end
	end

	// One input transaction. Payload goes out on the falling edge (after an optional
	// random gap) and is held until the block takes it at a rising edge.
	task automatic issue(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] d,
			input logic rdy, input logic [BYTE_W-1:0] dl, input logic [LEN_W-1:0] ml);
		@(negedge clk);
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
		end
		mode       = m;
		data       = d;
		line_ready = rdy;
		delimiter  = dl;
		max_len    = ml;
		in_valid   = 1'b1;
		do @(posedge clk); while (in_stall);
		n_sent++;
	endtask

	// Per-mode wrappers; fields a mode ignores get random values so all bits toggle.
	task automatic push_rx(input logic [BYTE_W-1:0] d);
		issue(MODE_RX_BYTE, d, 1'($urandom), BYTE_W'($urandom), LEN_W'($urandom));
	endtask

	task automatic queue_tx(input logic [BYTE_W-1:0] d);
		issue(MODE_TX_ENQ, d, 1'($urandom), BYTE_W'($urandom), LEN_W'($urandom));
	endtask

	task automatic tx_slot(input logic rdy);
		issue(MODE_TX_SLOT, BYTE_W'($urandom), rdy, BYTE_W'($urandom), LEN_W'($urandom));
	endtask

	task automatic read_rx();
		issue(MODE_RX_READ, BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom),
			LEN_W'($urandom));
	endtask

	task automatic read_line(input logic [BYTE_W-1:0] dl, input logic [LEN_W-1:0] ml);
		issue(MODE_READLINE, BYTE_W'($urandom), 1'($urandom), dl, ml);
	endtask

	task automatic clear_stats();
		issue(MODE_CLR_STATS, BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom),
			LEN_W'($urandom));
	endtask

	// Random byte that is not the delimiter, for well-formed lines.
	function automatic logic [BYTE_W-1:0] other_than(logic [BYTE_W-1:0] dl);
		logic [BYTE_W-1:0] b;
		b = BYTE_W'($urandom);
		if (b == dl)
			b = b ^ 8'h01;
		return b;
	endfunction

	initial begin
		int                k, pick;
		logic [BYTE_W-1:0] dl;
		logic [LEN_W-1:0]  ml;

		sb         = new();
		n_sent     = 0;
		calm       = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = MODE_RX_BYTE;
		data       = '0;
		line_ready = 1'b0;
		delimiter  = '0;
		max_len    = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed part ---
		// every read operation on empty rings
		read_rx();
		tx_slot(1'b1);
		read_line(8'h0A, 6'd63);
		// a two-byte line: first too long for max_len 0, then read out
		push_rx(8'h00);
		push_rx(8'hFF);
		push_rx(8'h0A);
		read_line(8'h0A, 6'd0);
		read_line(8'h0A, 6'd63);
		// delimiter alone: empty line, consumes just the delimiter
		push_rx(8'h0A);
		read_line(8'h0A, 6'd0);
		// line exactly max_len long
		push_rx(8'h11);
		push_rx(8'h22);
		push_rx(8'hFF);
		read_line(8'hFF, 6'd2);
		// transmit path, line not ready then ready
		queue_tx(8'hFF);
		queue_tx(8'h00);
		tx_slot(1'b0);
		tx_slot(1'b1);
		tx_slot(1'b1);
		// single byte reads
		push_rx(8'hA5);
		read_rx();
		clear_stats();
		// undefined mode codes
		issue(MODE_SPARE_6, 8'hFF, 1'b1, 8'hFF, 6'h3F);
		issue(MODE_SPARE_7, 8'h00, 1'b0, 8'h00, 6'h00);

		// --- random part ---
		// RX flood: overrun the ring, then take the longest possible line
		dl = BYTE_W'($urandom);
		for (k = 0; k < RX_DEPTH_DEF + 2; k++)
			push_rx(other_than(dl));
		push_rx(dl);
		read_line(dl, 6'd63);
		// TX flood: overrun, then drain with the odd not-ready slot
		for (k = 0; k < TX_DEPTH_DEF + 2; k++)
			queue_tx(BYTE_W'($urandom));
		for (k = 0; k < TX_DEPTH_DEF + 2; k++)
			tx_slot($urandom_range(99) < 90);

		while (n_sent < TARGET_ITEMS) begin
			calm = (n_sent >= 250 && n_sent < 330);
			pick = $urandom_range(99);
			if (pick < 40) begin
				// well-formed line, mostly short, now and then past the ring size
				dl = BYTE_W'($urandom);
				k  = ($urandom_range(9) == 0) ? $urandom_range(70, 13) : $urandom_range(12);
				repeat (k) push_rx(other_than(dl));
				push_rx(dl);
				if (k <= 63 && $urandom_range(99) < 70)
					ml = LEN_W'($urandom_range(63, k));
				else
					ml = LEN_W'($urandom);
				read_line(dl, ml);
			end else if (pick < 60) begin
				k = $urandom_range(8, 1);
				repeat (k) queue_tx(BYTE_W'($urandom));
				repeat (k + 1) tx_slot($urandom_range(99) < 80);
			end else if (pick < 70) begin
				repeat ($urandom_range(4, 1)) read_rx();
			end else if (pick < 74) begin
				clear_stats();
			end else begin
				// noise: any defined mode, all fields random
				issue(MODE_W'($urandom_range(MODE_CLR_STATS, MODE_RX_BYTE)),
					BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom), LEN_W'($urandom));
			end
		end
		calm = 1'b0;
		@(negedge clk);
		in_valid = 1'b0;

		// drain, then give the block time to show any stray result
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.n_errors++;
			$display("%0t: results outstanding, expected 0, actual %0d", $time, sb.pending());
		end

		$display("Ran %0d transactions in, checked %0d results, %0d lines read.",
			n_sent, sb.n_checked, sb.n_lines);
		$display("Saw %0d receive overruns and %0d transmit rejects; %0d mismatches.",
			sb.n_drops, sb.n_rejects, sb.n_errors);
		if (sb.n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		#(RUN_LIMIT_NS);
		$display("%0t: run limit reached", $time);
		$display("== FAIL ==");
		$finish;
	end

endmodule
